[rtl/core/owes_pkg.sv]
package owes_pkg;

  // bus event kinds carried in tuser
  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_BYTE  = 2'd1,
    EV_SLOT  = 2'd2,
    EV_ABORT = 2'd3
  } event_t;

  // function command bytes
  localparam logic [7:0] CMD_WRITE_SP = 8'h0F;
  localparam logic [7:0] CMD_READ_SP  = 8'hAA;
  localparam logic [7:0] CMD_COPY_SP  = 8'h55;
  localparam logic [7:0] CMD_READ_MEM = 8'hF0;

  localparam logic [7:0]  COPY_DONE_BYTE = 8'hAA;
  localparam logic [7:0]  PASSIVE_BYTE   = 8'hFF;
  localparam logic [7:0]  WP_CODE_RESET  = 8'h55;
  localparam logic [7:0]  EP_CODE_RESET  = 8'hAA;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // config register indexes
  localparam logic CFG_WP_CODE = 1'b0;
  localparam logic CFG_EP_CODE = 1'b1;

  // status area addresses
  localparam logic [7:0] STATUS_BASE = 8'h80;
  localparam logic [7:0] LAST_PAGE_BYTE = 8'd127;

  // transaction phase
  typedef enum logic [3:0] {
    PH_CMD, PH_PASSIVE, PH_WS_TA1, PH_WS_TA2, PH_WS_DATA, PH_WS_CRC, PH_RS,
    PH_CP_TA1, PH_CP_TA2, PH_CP_ES, PH_CP_DONE, PH_RM_TA1, PH_RM_TA2, PH_RM_SEND
  } phase_t;

  // sequencer state
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FIN_RD, ST_FIN_WB, ST_COPY, ST_DEC_RD, ST_DEC_WB, ST_RM_OUT
  } seq_t;

  // one result item toward the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] tx;
    logic       err;
  } result_t;

  // 1-wire crc16, reflected, one byte
  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

[rtl/core/owes_ram.sv]
module owes_ram #(
  parameter int DEPTH = 144,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/owes_ctrl.sv]
module owes_ctrl #(
  parameter int MEM_BYTES  = 144,
  parameter int PAGE_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          wp_code,
  input  logic [7:0]          ep_code,
  input  logic                evt_accept,
  input  owes_pkg::event_t    evt_mode,
  input  logic [7:0]          evt_byte,
  output logic                idle,
  output owes_pkg::result_t   res
);

  localparam int AW = $clog2(MEM_BYTES);

  owes_pkg::seq_t   state, state_next;
  owes_pkg::phase_t phase;
  logic [15:0] ta;
  logic [7:0]  es;
  logic [6:0]  pflags;
  logic [3:0]  eflags;
  logic [7:0]  bidx;
  logic [15:0] crc;
  logic [2:0]  soff;
  logic        err;
  logic [7:0]  scratch [8];
  logic [AW-1:0] cnt;
  logic [2:0]  hi;
  logic        fin_and;
  logic [7:0]  pos;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wd, ram_rd;

  logic       fin_go, fin_pf, fin_loop, fin_prot;
  logic [2:0] fin_e;
  logic       copy_go;
  logic [7:0] slot_tx;
  logic [8:0] cp_a;
  logic       cp_ok;

  function automatic logic is_prot(logic [7:0] a, logic [6:0] pf, logic [3:0] ef);
    logic r, hit;
    r = 1'b0;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!hit && ({1'b0, a} < 9'((k + 1) * PAGE_BYTES))) begin
        hit = 1'b1;
        r = pf[k];
      end
    end
    if (!hit) begin
      if (a >= owes_pkg::STATUS_BASE && a <= owes_pkg::STATUS_BASE + 8'd3) begin
        r = pf[a[1:0]] | pf[4] | ef[a[1:0]];
      end else if (a == owes_pkg::STATUS_BASE + 8'd5) begin
        r = pf[5] | pf[4];
      end else if (a == owes_pkg::STATUS_BASE + 8'd6 || a == owes_pkg::STATUS_BASE + 8'd7) begin
        r = pf[6] | pf[4];
      end else if (a > owes_pkg::LAST_PAGE_BYTE) begin
        r = pf[4];
      end
    end
    return r;
  endfunction

  function automatic logic is_ep(logic [7:0] a, logic [3:0] ef);
    logic r, hit;
    r = 1'b0;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!hit && ({1'b0, a} < 9'((k + 1) * PAGE_BYTES))) begin
        hit = 1'b1;
        r = ef[k];
      end
    end
    return r;
  endfunction

  owes_ram #(.DEPTH(MEM_BYTES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  assign idle = (state == owes_pkg::ST_IDLE);

  // scratchpad finish decision
  always_comb begin
    fin_go = 1'b0;
    fin_pf = 1'b0;
    fin_e  = bidx[2:0] - 3'd1;
    if (evt_accept && phase == owes_pkg::PH_WS_DATA) begin
      unique case (evt_mode)
        owes_pkg::EV_START: fin_go = 1'b1;
        owes_pkg::EV_ABORT: begin
          fin_go = 1'b1;
          fin_pf = 1'b1;
        end
        owes_pkg::EV_BYTE: begin
          fin_go = (bidx[2:0] == 3'd7);
          fin_e  = 3'd7;
        end
        default: fin_go = 1'b0;
      endcase
    end
    fin_prot = is_prot(ta[7:0], pflags, eflags);
    fin_loop = fin_go && (ta < 16'(4 * PAGE_BYTES))
               && (fin_prot || (is_ep(ta[7:0], eflags) && soff <= fin_e));
    copy_go = evt_accept && evt_mode == owes_pkg::EV_BYTE && phase == owes_pkg::PH_CP_ES
              && evt_byte == es && !fin_prot && !es[5];
  end

  // read slot byte
  always_comb begin
    slot_tx = owes_pkg::PASSIVE_BYTE;
    unique case (phase)
      owes_pkg::PH_WS_CRC: slot_tx = (bidx == 8'd0) ? ~crc[7:0] : ~crc[15:8];
      owes_pkg::PH_RS: begin
        priority case (bidx)
          8'd0: slot_tx = ta[7:0];
          8'd1: slot_tx = ta[15:8];
          8'd2: slot_tx = es;
          8'd3: slot_tx = scratch[soff];
          8'd4: slot_tx = ~crc[7:0];
          default: slot_tx = ~crc[15:8];
        endcase
      end
      owes_pkg::PH_CP_DONE: slot_tx = owes_pkg::COPY_DONE_BYTE;
      default: slot_tx = owes_pkg::PASSIVE_BYTE;
    endcase
  end

  // result item
  always_comb begin
    res = '0;
    if (state == owes_pkg::ST_RM_OUT) begin
      res.valid = 1'b1;
      res.tx    = ram_rd;
      res.err   = err;
    end else if (evt_accept && evt_mode == owes_pkg::EV_SLOT
                 && phase != owes_pkg::PH_RM_SEND) begin
      res.valid = 1'b1;
      res.tx    = slot_tx;
      res.err   = err;
    end else if (evt_accept && evt_mode == owes_pkg::EV_BYTE && phase == owes_pkg::PH_CMD
                 && evt_byte != owes_pkg::CMD_WRITE_SP && evt_byte != owes_pkg::CMD_READ_SP
                 && evt_byte != owes_pkg::CMD_COPY_SP && evt_byte != owes_pkg::CMD_READ_MEM)
    begin
      res.valid = 1'b1;
      res.tx    = owes_pkg::PASSIVE_BYTE;
      res.err   = 1'b1;
    end
  end

  // memory port
  assign cp_a  = 9'(pos) + 9'(cnt);
  assign cp_ok = (cp_a < 9'(MEM_BYTES)) && !is_prot(cp_a[7:0], pflags, eflags);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = bidx[AW-1:0];
    ram_wd   = scratch[cnt[2:0]];
    unique case (state)
      owes_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = cnt;
        ram_wd   = 8'h00;
      end
      owes_pkg::ST_FIN_RD: ram_addr = cp_a[AW-1:0];
      owes_pkg::ST_COPY: begin
        ram_we   = cp_ok;
        ram_addr = cp_a[AW-1:0];
      end
      owes_pkg::ST_DEC_RD: ram_addr = AW'(9'(owes_pkg::STATUS_BASE) + 9'(cnt));
      default: ram_addr = bidx[AW-1:0];
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      owes_pkg::ST_CLEAR:
        if (cnt == AW'(MEM_BYTES - 1)) state_next = owes_pkg::ST_IDLE;
      owes_pkg::ST_IDLE: begin
        if (fin_loop) begin
          state_next = owes_pkg::ST_FIN_RD;
        end else if (copy_go) begin
          state_next = owes_pkg::ST_COPY;
        end else if (evt_accept && evt_mode == owes_pkg::EV_SLOT
                     && phase == owes_pkg::PH_RM_SEND) begin
          state_next = owes_pkg::ST_RM_OUT;
        end
      end
      owes_pkg::ST_FIN_RD: state_next = owes_pkg::ST_FIN_WB;
      owes_pkg::ST_FIN_WB:
        state_next = (cnt[2:0] == hi) ? owes_pkg::ST_IDLE : owes_pkg::ST_FIN_RD;
      owes_pkg::ST_COPY:
        if (cnt[2:0] == 3'd7) begin
          state_next = (9'(pos) + 9'd8 > 9'(owes_pkg::LAST_PAGE_BYTE)) ?
                       owes_pkg::ST_DEC_RD : owes_pkg::ST_IDLE;
        end
      owes_pkg::ST_DEC_RD: state_next = owes_pkg::ST_DEC_WB;
      owes_pkg::ST_DEC_WB:
        state_next = (cnt[2:0] == 3'd5) ? owes_pkg::ST_IDLE : owes_pkg::ST_DEC_RD;
      owes_pkg::ST_RM_OUT: state_next = owes_pkg::ST_IDLE;
      default: state_next = owes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= owes_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // transaction state and sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= owes_pkg::PH_CMD;
      ta      <= '0;
      es      <= '0;
      pflags  <= '0;
      eflags  <= '0;
      bidx    <= '0;
      crc     <= '0;
      soff    <= '0;
      err     <= 1'b0;
      cnt     <= '0;
      hi      <= '0;
      fin_and <= 1'b0;
      pos     <= '0;
      for (int i = 0; i < 8; i++) scratch[i] <= 8'h00;
    end else begin
      unique case (state)
        owes_pkg::ST_CLEAR: cnt <= cnt + AW'(1);
        owes_pkg::ST_IDLE: if (evt_accept) begin
          // event handling
          unique case (evt_mode)
            owes_pkg::EV_START: begin
              phase <= owes_pkg::PH_CMD;
              err   <= 1'b0;
              bidx  <= '0;
            end
            owes_pkg::EV_ABORT: phase <= owes_pkg::PH_PASSIVE;
            owes_pkg::EV_SLOT: begin
              unique case (phase)
                owes_pkg::PH_WS_CRC:
                  if (bidx == 8'd0) bidx <= 8'd1;
                  else phase <= owes_pkg::PH_PASSIVE;
                owes_pkg::PH_RS: begin
                  if (bidx < 8'd4) crc <= owes_pkg::crc_step(crc, slot_tx);
                  if (bidx == 8'd3) begin
                    if (soff == es[2:0]) bidx <= 8'd4;
                    else soff <= soff + 3'd1;
                  end else if (bidx >= 8'd5) begin
                    phase <= owes_pkg::PH_PASSIVE;
                  end else begin
                    bidx <= bidx + 8'd1;
                  end
                end
                owes_pkg::PH_RM_SEND:
                  if (9'(bidx) + 9'd1 >= 9'(MEM_BYTES)) phase <= owes_pkg::PH_PASSIVE;
                  else bidx <= bidx + 8'd1;
                default: ;
              endcase
            end
            owes_pkg::EV_BYTE: begin
              unique case (phase)
                owes_pkg::PH_CMD: begin
                  crc  <= owes_pkg::crc_step(16'h0000, evt_byte);
                  bidx <= '0;
                  priority case (evt_byte)
                    owes_pkg::CMD_WRITE_SP: phase <= owes_pkg::PH_WS_TA1;
                    owes_pkg::CMD_READ_SP: begin
                      phase <= owes_pkg::PH_RS;
                      soff  <= ta[2:0];
                    end
                    owes_pkg::CMD_COPY_SP:  phase <= owes_pkg::PH_CP_TA1;
                    owes_pkg::CMD_READ_MEM: phase <= owes_pkg::PH_RM_TA1;
                    default: begin
                      phase <= owes_pkg::PH_PASSIVE;
                      err   <= 1'b1;
                    end
                  endcase
                end
                owes_pkg::PH_WS_TA1, owes_pkg::PH_RM_TA1: begin
                  ta[7:0] <= evt_byte;
                  crc     <= owes_pkg::crc_step(crc, evt_byte);
                  phase   <= (phase == owes_pkg::PH_WS_TA1) ?
                             owes_pkg::PH_WS_TA2 : owes_pkg::PH_RM_TA2;
                end
                owes_pkg::PH_WS_TA2: begin
                  ta[15:8] <= evt_byte;
                  crc      <= owes_pkg::crc_step(crc, evt_byte);
                  soff     <= ta[2:0];
                  bidx     <= {5'd0, ta[2:0]};
                  es       <= {5'd0, ta[2:0]};
                  phase    <= owes_pkg::PH_WS_DATA;
                end
                owes_pkg::PH_WS_DATA: begin
                  scratch[bidx[2:0]] <= evt_byte;
                  crc <= owes_pkg::crc_step(crc, evt_byte);
                  if (bidx[2:0] == 3'd7) begin
                    bidx  <= '0;
                    phase <= owes_pkg::PH_WS_CRC;
                  end else begin
                    bidx <= bidx + 8'd1;
                  end
                end
                owes_pkg::PH_CP_TA1:
                  phase <= (evt_byte == ta[7:0]) ? owes_pkg::PH_CP_TA2 : owes_pkg::PH_PASSIVE;
                owes_pkg::PH_CP_TA2:
                  phase <= (evt_byte == ta[15:8]) ? owes_pkg::PH_CP_ES : owes_pkg::PH_PASSIVE;
                owes_pkg::PH_CP_ES:
                  if (copy_go) begin
                    es[7]   <= 1'b1;
                    ta[2:0] <= 3'd0;
                    pos     <= {ta[7:3], 3'd0};
                    cnt     <= '0;
                    phase   <= owes_pkg::PH_CP_DONE;
                  end else begin
                    phase <= owes_pkg::PH_PASSIVE;
                  end
                owes_pkg::PH_RM_TA2: begin
                  ta[15:8] <= evt_byte;
                  if ({evt_byte, ta[7:0]} >= 16'(MEM_BYTES)) begin
                    phase <= owes_pkg::PH_PASSIVE;
                  end else begin
                    bidx  <= ta[7:0];
                    phase <= owes_pkg::PH_RM_SEND;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
          // scratchpad finish: end/status byte and merge setup
          if (fin_go) begin
            es      <= {2'b00, fin_pf, 2'b00, fin_e};
            pos     <= {ta[7:3], 3'd0};
            fin_and <= !fin_prot;
            cnt     <= fin_prot ? AW'(0) : AW'(soff);
            hi      <= fin_prot ? 3'd7 : fin_e;
          end
        end
        owes_pkg::ST_FIN_WB: begin
          scratch[cnt[2:0]] <= fin_and ? (scratch[cnt[2:0]] & ram_rd) : ram_rd;
          cnt <= cnt + AW'(1);
        end
        owes_pkg::ST_COPY: begin
          if (cnt[2:0] == 3'd7) begin
            cnt    <= '0;
            if (state_next == owes_pkg::ST_DEC_RD) begin
              pflags <= '0;
              eflags <= '0;
            end
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        owes_pkg::ST_DEC_WB: begin
          // status byte decode into protection and eprom flags
          priority case (cnt[2:0])
            3'd4: if (ram_rd == wp_code || ram_rd == ep_code) pflags[4] <= 1'b1;
            3'd5: begin
              if (ram_rd == ep_code) pflags[6:5] <= 2'b11;
              else if (ram_rd == wp_code) pflags[5] <= 1'b1;
            end
            default: begin
              if (ram_rd == wp_code) pflags[cnt[1:0]] <= 1'b1;
              if (ram_rd == ep_code) eflags[cnt[1:0]] <= 1'b1;
            end
          endcase
          cnt <= cnt + AW'(1);
        end
        default: ;
      endcase
    end
  end

  // items are taken only by the idle sequencer
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    evt_accept |-> state == owes_pkg::ST_IDLE)
    else $error("item accepted while sequencer busy");

  // memory is written only by the clearing pass and the copy
  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == owes_pkg::ST_CLEAR || state == owes_pkg::ST_COPY))
    else $error("unexpected memory write");

  // a memory read result follows a read slot accepted in the previous cycle
  a_rm_out: assert property (@(posedge clk) disable iff (rst)
    state == owes_pkg::ST_RM_OUT |-> $past(evt_accept) && $past(evt_mode) == owes_pkg::EV_SLOT)
    else $error("memory result without read slot");

  // copy starts only after a matching end/status byte
  a_copy_start: assert property (@(posedge clk) disable iff (rst)
    state == owes_pkg::ST_IDLE && state_next == owes_pkg::ST_COPY
    |=> phase == owes_pkg::PH_CP_DONE && es[7])
    else $error("copy without authorization");

endmodule

[rtl/core/onewire_eeprom_scratchpad_slave.sv]
// Byte-level memory-function engine of a 1-Wire 1Kbit EEPROM. Each input item is one
// bus event (tuser: 0 start, 1 master byte in tdata, 2 read slot, 3 abort); a read slot
// and a rejected command each return one item with the driven byte and the error flag.
// A read-memory slot goes through a registered memory read. Finishing write scratchpad
// reads and writes back each byte for the protected-page reload or the EPROM merge, a
// copy writes the scratchpad into its page, and a copy that reaches byte 127 or beyond
// also decodes the six control bytes again; all of these share the single memory port.
// After reset a clearing pass zeroes the memory and no item is taken meanwhile;
// configuration writes are taken at any time.
module onewire_eeprom_scratchpad_slave #(
  parameter int MEM_BYTES  = 144,
  parameter int PAGE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // rx_byte
  input  logic [1:0] s_tuser,   // mode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // tx_byte
  output logic       m_tuser,   // command_error
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] wp_code, ep_code;
  logic       idle, accept;
  owes_pkg::result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp_code <= owes_pkg::WP_CODE_RESET;
      ep_code <= owes_pkg::EP_CODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owes_pkg::CFG_WP_CODE: wp_code <= cfg_data;
        owes_pkg::CFG_EP_CODE: ep_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = idle && !m_tvalid;
  assign accept   = s_tvalid && s_tready;

  owes_ctrl #(.MEM_BYTES(MEM_BYTES), .PAGE_BYTES(PAGE_BYTES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .wp_code    (wp_code),
    .ep_code    (ep_code),
    .evt_accept (accept),
    .evt_mode   (owes_pkg::event_t'(s_tuser)),
    .evt_byte   (s_tdata),
    .idle       (idle),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= res.tx;
      m_tuser <= res.err;
    end
  end

endmodule

[tb/tb_onewire_eeprom_scratchpad_slave.sv]
module tb_onewire_eeprom_scratchpad_slave;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BYTES = 144;
  localparam int PAGE_LEN  = 32;
  localparam int QUIET_CYCLES = 60;

  typedef struct packed {
    owes_pkg::event_t kind;
    logic [7:0]       data;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       err;
  } slot_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic [1:0] s_tuser = 2'b00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  onewire_eeprom_scratchpad_slave uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow state of the device
  logic [7:0]       mem_img [NUM_BYTES];
  logic [7:0]       pad_img [8];
  logic [15:0]      ta_reg;
  logic [7:0]       es_reg;
  logic [6:0]       prot_bits;
  logic [3:0]       eprom_bits;
  owes_pkg::phase_t cur_phase;
  logic [7:0]       pos_idx;
  logic [15:0]      crc_reg;
  logic [2:0]       first_off;
  logic             err_reg;
  logic [7:0]       wp_code;
  logic [7:0]       ep_code;

  bus_item_t    pending_items[$];
  slot_result_t expected_slots[$];
  int unsigned  items_queued = 0;
  int unsigned  items_taken = 0;
  int unsigned  mismatches = 0;

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic logic [7:0] mem_rd(int a);
    return (a < NUM_BYTES) ? mem_img[a] : 8'h00;
  endfunction

  // rebuild protection flags from the control bytes
  function automatic void decode_ctrl();
    logic [6:0] p;
    logic [3:0] e;
    p = '0;
    e = '0;
    for (int k = 0; k < 4; k++) begin
      if (mem_rd(8'h80 + k) == wp_code) p[k] = 1'b1;
      if (mem_rd(8'h80 + k) == ep_code) e[k] = 1'b1;
    end
    if (mem_rd(8'h84) == wp_code || mem_rd(8'h84) == ep_code) p[4] = 1'b1;
    if (mem_rd(8'h85) == wp_code) p[5] = 1'b1;
    if (mem_rd(8'h85) == ep_code) begin
      p[6] = 1'b1;
      p[5] = 1'b1;
    end
    prot_bits = p;
    eprom_bits = e;
  endfunction

  function automatic bit addr_locked(logic [7:0] a);
    for (int k = 0; k < 4; k++)
      if (a < (k + 1) * PAGE_LEN) return prot_bits[k];
    if (a >= 8'h80 && a <= 8'h83)
      return prot_bits[a - 8'h80] | prot_bits[4] | eprom_bits[a - 8'h80];
    if (a == 8'h85) return prot_bits[5] | prot_bits[4];
    if (a == 8'h86 || a == 8'h87) return prot_bits[6] | prot_bits[4];
    if (a > 8'd127) return prot_bits[4];
    return 1'b0;
  endfunction

  function automatic bit addr_eprom(logic [7:0] a);
    for (int k = 0; k < 4; k++)
      if (a < (k + 1) * PAGE_LEN) return eprom_bits[k];
    return 1'b0;
  endfunction

  // close a write scratchpad: ending offset, reload or eprom merge
  function automatic void close_write(bit pf);
    logic [2:0] e;
    logic [7:0] lo;
    int base;
    e = 3'(pos_idx - 8'd1);
    lo = ta_reg[7:0];
    base = lo & 8'hF8;
    es_reg = {2'b00, pf, 2'b00, e};
    if (ta_reg < 4 * PAGE_LEN) begin
      if (addr_locked(lo)) begin
        for (int i = 0; i < 8; i++) pad_img[i] = mem_rd(base + i);
      end else if (addr_eprom(lo)) begin
        for (int i = first_off; i <= e; i++) pad_img[i & 7] = pad_img[i & 7] & mem_rd(base + i);
      end
    end
  endfunction

  function automatic void copy_pad(int base);
    for (int i = 0; i < 8; i++) begin
      if (base + i >= NUM_BYTES) break;
      if (!addr_locked(8'(base + i))) mem_img[base + i] = pad_img[i];
    end
    if (base + 8 > 127) decode_ctrl();
  endfunction

  function automatic void master_byte(logic [7:0] b);
    case (cur_phase)
      owes_pkg::PH_CMD: begin
        crc_reg = crc16_byte(16'h0000, b);
        pos_idx = 8'h00;
        case (b)
          owes_pkg::CMD_WRITE_SP: cur_phase = owes_pkg::PH_WS_TA1;
          owes_pkg::CMD_READ_SP: begin
            cur_phase = owes_pkg::PH_RS;
            first_off = ta_reg[2:0];
          end
          owes_pkg::CMD_COPY_SP: cur_phase = owes_pkg::PH_CP_TA1;
          owes_pkg::CMD_READ_MEM: cur_phase = owes_pkg::PH_RM_TA1;
          default: begin
            cur_phase = owes_pkg::PH_PASSIVE;
            err_reg = 1'b1;
            expected_slots.push_back('{tx: owes_pkg::PASSIVE_BYTE, err: 1'b1});
          end
        endcase
      end
      owes_pkg::PH_WS_TA1, owes_pkg::PH_RM_TA1: begin
        ta_reg[7:0] = b;
        crc_reg = crc16_byte(crc_reg, b);
        cur_phase = (cur_phase == owes_pkg::PH_WS_TA1) ?
                    owes_pkg::PH_WS_TA2 : owes_pkg::PH_RM_TA2;
      end
      owes_pkg::PH_WS_TA2: begin
        ta_reg[15:8] = b;
        crc_reg = crc16_byte(crc_reg, b);
        first_off = ta_reg[2:0];
        pos_idx = {5'd0, first_off};
        es_reg = {5'd0, first_off};
        cur_phase = owes_pkg::PH_WS_DATA;
      end
      owes_pkg::PH_WS_DATA: begin
        pad_img[pos_idx[2:0]] = b;
        crc_reg = crc16_byte(crc_reg, b);
        pos_idx = pos_idx + 8'd1;
        if (pos_idx >= 8) begin
          close_write(1'b0);
          pos_idx = 8'h00;
          cur_phase = owes_pkg::PH_WS_CRC;
        end
      end
      owes_pkg::PH_CP_TA1:
        cur_phase = (b == ta_reg[7:0]) ? owes_pkg::PH_CP_TA2 : owes_pkg::PH_PASSIVE;
      owes_pkg::PH_CP_TA2:
        cur_phase = (b == ta_reg[15:8]) ? owes_pkg::PH_CP_ES : owes_pkg::PH_PASSIVE;
      owes_pkg::PH_CP_ES: begin
        cur_phase = owes_pkg::PH_PASSIVE;
        if (b == es_reg && !addr_locked(ta_reg[7:0]) && !es_reg[5]) begin
          es_reg[7] = 1'b1;
          ta_reg = ta_reg & 16'hFFF8;
          copy_pad(ta_reg[7:0]);
          cur_phase = owes_pkg::PH_CP_DONE;
        end
      end
      owes_pkg::PH_RM_TA2: begin
        ta_reg[15:8] = b;
        if (ta_reg >= NUM_BYTES) cur_phase = owes_pkg::PH_PASSIVE;
        else begin
          pos_idx = ta_reg[7:0];
          cur_phase = owes_pkg::PH_RM_SEND;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] slot_byte();
    logic [7:0] t;
    t = owes_pkg::PASSIVE_BYTE;
    case (cur_phase)
      owes_pkg::PH_WS_CRC: begin
        t = (pos_idx == 0) ? ~crc_reg[7:0] : ~crc_reg[15:8];
        if (pos_idx == 0) pos_idx = 8'd1;
        else cur_phase = owes_pkg::PH_PASSIVE;
      end
      owes_pkg::PH_RS: begin
        case (pos_idx)
          8'd0: t = ta_reg[7:0];
          8'd1: t = ta_reg[15:8];
          8'd2: t = es_reg;
          8'd3: t = pad_img[first_off];
          8'd4: t = ~crc_reg[7:0];
          default: t = ~crc_reg[15:8];
        endcase
        if (pos_idx < 4) crc_reg = crc16_byte(crc_reg, t);
        if (pos_idx == 3) begin
          if (first_off == es_reg[2:0]) pos_idx = 8'd4;
          else first_off = first_off + 3'd1;
        end else if (pos_idx >= 5) cur_phase = owes_pkg::PH_PASSIVE;
        else pos_idx = pos_idx + 8'd1;
      end
      owes_pkg::PH_CP_DONE: t = owes_pkg::COPY_DONE_BYTE;
      owes_pkg::PH_RM_SEND: begin
        t = mem_rd(pos_idx);
        if (pos_idx + 1 >= NUM_BYTES) cur_phase = owes_pkg::PH_PASSIVE;
        else pos_idx = pos_idx + 8'd1;
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic void predict_event(owes_pkg::event_t kind, logic [7:0] b);
    logic [7:0] t;
    case (kind)
      owes_pkg::EV_START: begin
        if (cur_phase == owes_pkg::PH_WS_DATA) close_write(1'b0);
        cur_phase = owes_pkg::PH_CMD;
        err_reg = 1'b0;
        pos_idx = 8'h00;
      end
      owes_pkg::EV_BYTE: master_byte(b);
      owes_pkg::EV_SLOT: begin
        t = slot_byte();
        expected_slots.push_back('{tx: t, err: err_reg});
      end
      default: begin
        if (cur_phase == owes_pkg::PH_WS_DATA) close_write(1'b1);
        cur_phase = owes_pkg::PH_PASSIVE;
      end
    endcase
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  int gap_pct = 30;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        bus_item_t it;
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= it.data;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes over time
  int stall_left = 0;
  int stall_pct = 0;
  int cycle_no = 0;
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no % 500 == 0) begin
      stall_pct <= $urandom_range(0, 3) * 15;
      gap_pct <= $urandom_range(0, 3) * 20;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left <= $urandom_range(1, 6);
    end
  end

  // monitor: check results, then track accepted items
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_slots.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result: tx=%h err=%b", m_tdata, m_tuser);
      end else begin
        slot_result_t exp_r;
        exp_r = expected_slots.pop_front();
        if (exp_r.tx !== m_tdata || exp_r.err !== m_tuser) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: expected tx=%h err=%b, got tx=%h err=%b",
                     exp_r.tx, exp_r.err, m_tdata, m_tuser);
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      predict_event(owes_pkg::event_t'(s_tuser), s_tdata);
      items_taken <= items_taken + 1;
    end
  end

  task automatic put(owes_pkg::event_t kind, logic [7:0] b);
    pending_items.push_back('{kind: kind, data: b});
    items_queued++;
  endtask

  task automatic drain();
    @(posedge clk);
    while (items_taken != items_queued) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_codes(logic [7:0] wp, logic [7:0] ep);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= owes_pkg::CFG_WP_CODE;
    cfg_data <= wp;
    @(posedge clk);
    cfg_index <= owes_pkg::CFG_EP_CODE;
    cfg_data <= ep;
    @(posedge clk);
    cfg_we <= 1'b0;
    wp_code = wp;
    ep_code = ep;
  endtask

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(0, NUM_BYTES - 1));
    if (r < 85) return 16'($urandom_range(8'h80, 8'h87));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_data(logic [15:0] a);
    if (a >= 16'h80 && a <= 16'h87 && $urandom_range(0, 2) != 0)
      return $urandom_range(0, 1) ? wp_code : ep_code;
    return 8'($urandom);
  endfunction

  task automatic write_pad(logic [15:0] a, int n, int slots, bit abort_end);
    put(owes_pkg::EV_START, 8'h00);
    put(owes_pkg::EV_BYTE, owes_pkg::CMD_WRITE_SP);
    put(owes_pkg::EV_BYTE, a[7:0]);
    put(owes_pkg::EV_BYTE, a[15:8]);
    for (int i = 0; i < n; i++) put(owes_pkg::EV_BYTE, pick_data(a));
    if (abort_end) put(owes_pkg::EV_ABORT, 8'h00);
    for (int i = 0; i < slots; i++) put(owes_pkg::EV_SLOT, 8'h00);
  endtask

  task automatic read_pad(int slots);
    put(owes_pkg::EV_START, 8'h00);
    put(owes_pkg::EV_BYTE, owes_pkg::CMD_READ_SP);
    for (int i = 0; i < slots; i++) put(owes_pkg::EV_SLOT, 8'h00);
  endtask

  // authorization bytes come from the shadow state once the bus is quiet
  task automatic copy_pad_bus(bit spoil, int slots);
    logic [7:0] auth [3];
    drain();
    auth[0] = ta_reg[7:0];
    auth[1] = ta_reg[15:8];
    auth[2] = es_reg;
    if (spoil) auth[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
    put(owes_pkg::EV_START, 8'h00);
    put(owes_pkg::EV_BYTE, owes_pkg::CMD_COPY_SP);
    for (int i = 0; i < 3; i++) put(owes_pkg::EV_BYTE, auth[i]);
    for (int i = 0; i < slots; i++) put(owes_pkg::EV_SLOT, 8'h00);
  endtask

  task automatic read_mem(logic [15:0] a, int slots);
    put(owes_pkg::EV_START, 8'h00);
    put(owes_pkg::EV_BYTE, owes_pkg::CMD_READ_MEM);
    put(owes_pkg::EV_BYTE, a[7:0]);
    put(owes_pkg::EV_BYTE, a[15:8]);
    for (int i = 0; i < slots; i++) put(owes_pkg::EV_SLOT, 8'h00);
  endtask

  task automatic random_traffic(int count);
    int target;
    logic [15:0] a;
    target = items_queued + count;
    while (items_queued < target) begin
      a = pick_addr();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          int room;
          room = 8 - a[2:0];
          if ($urandom_range(0, 3) != 0) write_pad(a, room, $urandom_range(0, 3), 1'b0);
          else write_pad(a, $urandom_range(0, room), $urandom_range(0, 2),
                         $urandom_range(0, 1));
          if ($urandom_range(0, 1)) copy_pad_bus($urandom_range(0, 4) == 0,
                                                 $urandom_range(0, 3));
        end
        3, 4: read_pad($urandom_range(1, 14));
        5: copy_pad_bus($urandom_range(0, 3) == 0, $urandom_range(0, 3));
        6, 7: begin
          if ($urandom_range(0, 5) == 0) read_mem(16'($urandom_range(130, 143)), 20);
          else read_mem(a, $urandom_range(1, 12));
        end
        default: begin
          int n;
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            put(owes_pkg::event_t'($urandom_range(0, 3)), 8'($urandom));
        end
      endcase
      if ($urandom_range(0, 199) == 0) settle();
    end
  endtask

  initial begin
    wp_code = owes_pkg::WP_CODE_RESET;
    ep_code = owes_pkg::EP_CODE_RESET;
    for (int i = 0; i < NUM_BYTES; i++) mem_img[i] = 8'h00;
    for (int i = 0; i < 8; i++) pad_img[i] = 8'h00;
    ta_reg = '0;
    es_reg = '0;
    cur_phase = owes_pkg::PH_CMD;
    pos_idx = '0;
    crc_reg = '0;
    first_off = '0;
    err_reg = 1'b0;
    decode_ctrl();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: unknown command, wrong direction, short write, copy, reads
    put(owes_pkg::EV_START, 8'h00);
    put(owes_pkg::EV_BYTE, 8'h00);
    put(owes_pkg::EV_SLOT, 8'h00);
    put(owes_pkg::EV_START, 8'h00);
    put(owes_pkg::EV_SLOT, 8'h00);
    write_pad(16'h0005, 3, 0, 1'b0);
    put(owes_pkg::EV_START, 8'h00);
    write_pad(16'h0003, 0, 1, 1'b0);
    read_pad(7);
    put(owes_pkg::EV_BYTE, 8'hFF);
    write_pad(16'h0000, 8, 3, 1'b0);
    copy_pad_bus(1'b0, 2);
    read_mem(16'h0000, 3);
    read_mem(16'h008F, 2);
    read_mem(16'h0100, 1);
    write_pad(16'h0040, 2, 0, 1'b1);
    copy_pad_bus(1'b0, 1);
    put(owes_pkg::EV_ABORT, 8'h00);
    put(owes_pkg::EV_SLOT, 8'h00);

    random_traffic(400);
    settle();
    random_traffic(100);
    set_codes(8'($urandom), 8'($urandom));
    random_traffic(400);
    set_codes(8'hFF, 8'hFE);
    random_traffic(400);
    set_codes(8'h00, 8'hFF);
    random_traffic(400);
    set_codes(8'hFF, 8'h00);
    random_traffic(400);

    settle();
    if (mismatches == 0 && expected_slots.size() == 0) begin
      $display("** onewire_eeprom_scratchpad_slave: PASSED **");
    end else begin
      $display("** onewire_eeprom_scratchpad_slave: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("** onewire_eeprom_scratchpad_slave: FAILED **");
    $finish;
  end

endmodule
